@@ design/tgrf_pkg.sv @@
// shared constants and types for the touch ghost reject filter
package tgrf_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned JUMP_W   = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WINDOW_W-1:0] BUSY_WINDOW_RESET = WINDOW_W'(150);
  localparam logic [JUMP_W-1:0]   MAX_JUMP_RESET    = JUMP_W'(30);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP    = 1'd1;

  // event kinds carried in tuser
  localparam logic ACT_POLL  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic               pressed;
    logic               held_back;
    logic [COUNT_W-1:0] raw_total;
    logic [COUNT_W-1:0] suppressed_total;
  } tgrf_verdict_t;

endpackage

@@ design/touch_ghost_reject_filter.sv @@
// top level of the touch ghost reject filter: input and result registers
// Touch ghost reject filter. Events enter on the slave stream (tuser = kind:
// poll or panel flush) and are registered, judged combinationally against the
// filter state and written to a result register; a flush updates the flush
// timestamp and yields no result beat, each poll yields exactly one. One
// event is taken every cycle while the result side keeps up, passing the input
// register and then the result register; the only limit is the single result
// register, which stalls the input when the result beat is not taken.
// Configuration writes (busy window, max jump) must happen while no event is
// in flight.
module touch_ghost_reject_filter
  import tgrf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // time_ms, touched, touch_x, touch_y, zero pad
  input  logic [((TIME_W+1+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pressed, point_x, point_y, held_back, raw_touch_total, suppressed_total, zero pad
  output logic [((2+2*COORD_BITS+2*COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_N = 2 + 2*COORD_BITS + 2*COUNT_W;
  localparam int unsigned OUT_W = ((OUT_N + 7) / 8) * 8;

  logic                  in_valid_q;
  logic                  action_q;
  logic [TIME_W-1:0]     time_q;
  logic                  touched_q;
  logic [COORD_BITS-1:0] x_q, y_q;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;

  logic                  out_free, advance, emit;
  logic [COORD_BITS-1:0] point_x, point_y;
  tgrf_verdict_t         verdict;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && ((action_q == ACT_FLUSH) || out_free);
  assign emit          = advance && (action_q == ACT_POLL);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q  <= s_axis_tuser;
      time_q    <= s_axis_tdata[TIME_W-1:0];
      touched_q <= s_axis_tdata[TIME_W];
      x_q       <= s_axis_tdata[TIME_W+1 +: COORD_BITS];
      y_q       <= s_axis_tdata[TIME_W+1+COORD_BITS +: COORD_BITS];
    end
  end

  tgrf_judge #(
    .COORD_BITS(COORD_BITS)
  ) u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .action_i   (action_q),
    .time_i     (time_q),
    .touched_i  (touched_q),
    .x_i        (x_q),
    .y_i        (y_q),
    .point_x_o  (point_x),
    .point_y_o  (point_y),
    .verdict_o  (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= OUT_W'({verdict.suppressed_total, verdict.raw_total,
                            verdict.held_back, point_y, point_x, verdict.pressed});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/tgrf_judge.sv @@
// filter state, configuration registers and the per-event decision logic
module tgrf_judge
  import tgrf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  advance_i,
  input  logic                  action_i,
  input  logic [TIME_W-1:0]     time_i,
  input  logic                  touched_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output tgrf_verdict_t         verdict_o
);

  localparam int unsigned CMP_W = (COORD_BITS > JUMP_W) ? COORD_BITS : JUMP_W;

  logic [WINDOW_W-1:0]   window_q;
  logic [JUMP_W-1:0]     jump_q;
  logic [TIME_W-1:0]     last_flush_q;
  logic                  contact_q;
  logic                  pending_q;
  logic [COORD_BITS-1:0] pend_x_q, pend_y_q;
  logic [COUNT_W-1:0]    raw_q, sup_q;

  logic [COUNT_W-1:0]    raw_d, sup_d;
  logic [TIME_W-1:0]     since_flush;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  busy, near, accept, poll, touch_poll, hold;

  assign poll        = (action_i == ACT_POLL);
  assign touch_poll  = poll && touched_i;
  assign since_flush = time_i - last_flush_q;
  assign busy        = since_flush < TIME_W'(window_q);
  assign dx          = (x_i >= pend_x_q) ? (x_i - pend_x_q) : (pend_x_q - x_i);
  assign dy          = (y_i >= pend_y_q) ? (y_i - pend_y_q) : (pend_y_q - y_i);
  assign near        = pending_q && (CMP_W'(dx) <= CMP_W'(jump_q))
                                 && (CMP_W'(dy) <= CMP_W'(jump_q));
  assign accept      = contact_q || !busy || near;
  assign hold        = touch_poll && !accept;

  assign raw_d = touch_poll ? (raw_q + COUNT_W'(1)) : raw_q;
  assign sup_d = hold ? (sup_q + COUNT_W'(1)) : sup_q;

  always_comb begin
    verdict_o.pressed          = touch_poll && accept;
    verdict_o.held_back        = hold;
    verdict_o.raw_total        = raw_d;
    verdict_o.suppressed_total = sup_d;
    point_x_o = (touch_poll && accept) ? x_i : '0;
    point_y_o = (touch_poll && accept) ? y_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= BUSY_WINDOW_RESET;
      jump_q   <= MAX_JUMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BUSY_WINDOW: window_q <= cfg_data_i;
        REG_MAX_JUMP:    jump_q   <= cfg_data_i[JUMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_flush_q <= '0;
      contact_q    <= 1'b0;
      pending_q    <= 1'b0;
      raw_q        <= '0;
      sup_q        <= '0;
    end else if (advance_i) begin
      raw_q <= raw_d;
      sup_q <= sup_d;
      if (!poll) begin
        last_flush_q <= time_i;
      end else if (!touched_i) begin
        contact_q <= 1'b0;
        pending_q <= 1'b0;
      end else if (accept) begin
        contact_q <= 1'b1;
        pending_q <= 1'b0;
      end else begin
        pending_q <= 1'b1;
      end
    end
  end

  // held sample coordinates, only meaningful while pending_q is set
  always_ff @(posedge clk_i) begin
    if (advance_i && hold) begin
      pend_x_q <= x_i;
      pend_y_q <= y_i;
    end
  end

  a_pending_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(contact_q && pending_q))
    else $error("contact accepted while a sample is still pending");

  a_hold_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && hold |=> sup_q == $past(sup_q) + COUNT_W'(1) && pending_q)
    else $error("held sample not counted or not kept pending");

  a_flush_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !poll |=> last_flush_q == $past(time_i)
                           && raw_q == $past(raw_q) && sup_q == $past(sup_q))
    else $error("flush event mishandled");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && poll && !touched_i |=> !contact_q && !pending_q)
    else $error("release did not clear contact state");

endmodule
